// ===== design/dips_pkg.sv =====
// Shared types and constants for the dual-wheel incremental PID speed controller.
`timescale 1ns / 1ps

package dips_pkg;

    localparam int DATA_W  = 16;
    localparam int GAIN_W  = 16;
    localparam int LIMIT_W = 15;
    localparam int IDX_W   = 3;
    localparam int CFG_W   = 16;

    // pipeline payload widths
    localparam int D1_W   = DATA_W + 1;
    localparam int D2_W   = DATA_W + 2;
    localparam int PP_W   = GAIN_W + 1 + D1_W;
    localparam int PI_W   = GAIN_W + 1 + DATA_W;
    localparam int PD_W   = GAIN_W + 1 + D2_W;
    localparam int PSUM_W = PD_W + 2;
    localparam int ACC_W  = PSUM_W + 1;
    localparam int Q_W    = ACC_W - 8;

    // register indexes
    localparam logic [IDX_W-1:0] REG_LEFT_KP      = 3'd0;
    localparam logic [IDX_W-1:0] REG_LEFT_KI      = 3'd1;
    localparam logic [IDX_W-1:0] REG_LEFT_KD      = 3'd2;
    localparam logic [IDX_W-1:0] REG_RIGHT_KP     = 3'd3;
    localparam logic [IDX_W-1:0] REG_RIGHT_KI     = 3'd4;
    localparam logic [IDX_W-1:0] REG_RIGHT_KD     = 3'd5;
    localparam logic [IDX_W-1:0] REG_OUTPUT_LIMIT = 3'd6;

    // reset values: kp 20.0, ki 2.5, kd 0 in Q8.8
    localparam logic [GAIN_W-1:0]  KP_RESET    = 16'd5120;
    localparam logic [GAIN_W-1:0]  KI_RESET    = 16'd640;
    localparam logic [GAIN_W-1:0]  KD_RESET    = 16'd0;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 15'd9900;

    typedef struct packed {
        logic [GAIN_W-1:0] kp;
        logic [GAIN_W-1:0] ki;
        logic [GAIN_W-1:0] kd;
    } gain_set_t;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } stage_en_t;

endpackage

// ===== design/dips_cfg.sv =====
// Configuration register file: per-wheel gains and the shared output limit.
`timescale 1ns / 1ps

module dips_cfg
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    input  logic [dips_pkg::IDX_W-1:0]      cfg_index,
    input  logic [dips_pkg::CFG_W-1:0]      cfg_data,
    output dips_pkg::gain_set_t             left_gains,
    output dips_pkg::gain_set_t             right_gains,
    output logic [dips_pkg::LIMIT_W-1:0]    limit
);

    dips_pkg::gain_set_t              left_reg;
    dips_pkg::gain_set_t              right_reg;
    logic [dips_pkg::LIMIT_W-1:0]     limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg.kp  <= dips_pkg::KP_RESET;
            left_reg.ki  <= dips_pkg::KI_RESET;
            left_reg.kd  <= dips_pkg::KD_RESET;
            right_reg.kp <= dips_pkg::KP_RESET;
            right_reg.ki <= dips_pkg::KI_RESET;
            right_reg.kd <= dips_pkg::KD_RESET;
            limit_reg    <= dips_pkg::LIMIT_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                dips_pkg::REG_LEFT_KP:      left_reg.kp  <= cfg_data;
                dips_pkg::REG_LEFT_KI:      left_reg.ki  <= cfg_data;
                dips_pkg::REG_LEFT_KD:      left_reg.kd  <= cfg_data;
                dips_pkg::REG_RIGHT_KP:     right_reg.kp <= cfg_data;
                dips_pkg::REG_RIGHT_KI:     right_reg.ki <= cfg_data;
                dips_pkg::REG_RIGHT_KD:     right_reg.kd <= cfg_data;
                dips_pkg::REG_OUTPUT_LIMIT: limit_reg    <= cfg_data[dips_pkg::LIMIT_W-1:0];
                default:                    ; // unmapped index, ignored
            endcase
        end
    end

    assign left_gains  = left_reg;
    assign right_gains = right_reg;
    assign limit       = limit_reg;

endmodule

// ===== design/dips_lane.sv =====
// One wheel lane: error history, gain multiplies, sum, and drive accumulator update.
`timescale 1ns / 1ps

module dips_lane
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  dips_pkg::stage_en_t                     en,
    input  logic signed [dips_pkg::DATA_W-1:0]      target,
    input  logic signed [dips_pkg::DATA_W-1:0]      count,
    input  dips_pkg::gain_set_t                     gains,
    input  logic [dips_pkg::LIMIT_W-1:0]            limit,
    output logic signed [dips_pkg::DATA_W-1:0]      drive
);

    // stage 1: error and differences
    logic signed [dips_pkg::DATA_W:0]     diff;
    logic signed [dips_pkg::DATA_W-1:0]   err_next;
    logic signed [dips_pkg::D1_W-1:0]     d1_next;
    logic signed [dips_pkg::D2_W-1:0]     d2_next;
    logic signed [dips_pkg::DATA_W-1:0]   last_err_reg;
    logic signed [dips_pkg::DATA_W-1:0]   older_err_reg;
    logic signed [dips_pkg::DATA_W-1:0]   err_reg;
    logic signed [dips_pkg::D1_W-1:0]     d1_reg;
    logic signed [dips_pkg::D2_W-1:0]     d2_reg;

    // stage 2: products
    logic signed [dips_pkg::GAIN_W:0]     kp_s;
    logic signed [dips_pkg::GAIN_W:0]     ki_s;
    logic signed [dips_pkg::GAIN_W:0]     kd_s;
    logic signed [dips_pkg::PP_W-1:0]     prod_p_next;
    logic signed [dips_pkg::PI_W-1:0]     prod_i_next;
    logic signed [dips_pkg::PD_W-1:0]     prod_d_next;
    logic signed [dips_pkg::PP_W-1:0]     prod_p_reg;
    logic signed [dips_pkg::PI_W-1:0]     prod_i_reg;
    logic signed [dips_pkg::PD_W-1:0]     prod_d_reg;

    // stage 3: sum of products
    logic signed [dips_pkg::PSUM_W-1:0]   psum_next;
    logic signed [dips_pkg::PSUM_W-1:0]   psum_reg;

    // stage 4: accumulate, truncate toward zero, clamp
    logic signed [dips_pkg::ACC_W-1:0]    acc;
    logic signed [dips_pkg::Q_W-1:0]      q;
    logic signed [dips_pkg::Q_W-1:0]      lim_s;
    logic signed [dips_pkg::Q_W-1:0]      q_clamped;
    logic signed [dips_pkg::DATA_W-1:0]   drive_next;
    logic signed [dips_pkg::DATA_W-1:0]   drive_reg;

    always_comb
    begin
        diff = {target[dips_pkg::DATA_W-1], target} - {count[dips_pkg::DATA_W-1], count};
        unique case (diff[dips_pkg::DATA_W:dips_pkg::DATA_W-1])
            2'b01:   err_next = {1'b0, {(dips_pkg::DATA_W-1){1'b1}}};
            2'b10:   err_next = {1'b1, {(dips_pkg::DATA_W-1){1'b0}}};
            default: err_next = diff[dips_pkg::DATA_W-1:0];
        endcase
        d1_next = {err_next[dips_pkg::DATA_W-1], err_next}
                - {last_err_reg[dips_pkg::DATA_W-1], last_err_reg};
        d2_next = {{2{err_next[dips_pkg::DATA_W-1]}}, err_next}
                - {last_err_reg[dips_pkg::DATA_W-1], last_err_reg, 1'b0}
                + {{2{older_err_reg[dips_pkg::DATA_W-1]}}, older_err_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_err_reg  <= '0;
            older_err_reg <= '0;
        end
        else if (en.s1)
        begin
            last_err_reg  <= err_next;
            older_err_reg <= last_err_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            err_reg <= err_next;
            d1_reg  <= d1_next;
            d2_reg  <= d2_next;
        end
    end

    always_comb
    begin
        kp_s        = {1'b0, gains.kp};
        ki_s        = {1'b0, gains.ki};
        kd_s        = {1'b0, gains.kd};
        prod_p_next = kp_s * d1_reg;
        prod_i_next = ki_s * err_reg;
        prod_d_next = kd_s * d2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            prod_p_reg <= prod_p_next;
            prod_i_reg <= prod_i_next;
            prod_d_reg <= prod_d_next;
        end
    end

    assign psum_next = dips_pkg::PSUM_W'(prod_p_reg) + dips_pkg::PSUM_W'(prod_i_reg)
                     + dips_pkg::PSUM_W'(prod_d_reg);

    always_ff @(posedge clk)
    begin
        if (en.s3)
        begin
            psum_reg <= psum_next;
        end
    end

    always_comb
    begin
        acc = {{(dips_pkg::ACC_W-dips_pkg::DATA_W-8){drive_reg[dips_pkg::DATA_W-1]}},
               drive_reg, 8'h00}
            + {psum_reg[dips_pkg::PSUM_W-1], psum_reg};
        // floor shift, then bump toward zero when negative with a remainder
        q = acc[dips_pkg::ACC_W-1:8]
          + dips_pkg::Q_W'(acc[dips_pkg::ACC_W-1] && (psum_reg[7:0] != 8'h00));
        lim_s = {{(dips_pkg::Q_W-dips_pkg::LIMIT_W){1'b0}}, limit};
        priority if (q > lim_s)
            q_clamped = lim_s;
        else if (q < -lim_s)
            q_clamped = -lim_s;
        else
            q_clamped = q;
        drive_next = q_clamped[dips_pkg::DATA_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drive_reg <= '0;
        end
        else if (en.s4)
        begin
            drive_reg <= drive_next;
        end
    end

    assign drive = drive_reg;

endmodule

// ===== design/dual_incremental_pid_speed.sv =====
// Top level: dual-wheel incremental PID speed controller with two parallel lanes.
`timescale 1ns / 1ps

// Takes one request per clock while in_stall is low. Its duty/reverse result shows on
// out_valid after the error, multiply, sum and accumulate stages (one lane per wheel).
// Stages without an item collapse, so requests are still taken while a result waits on
// out_stall. Throughput is set by the drive accumulator loop in the last stage: one add,
// truncate and clamp per cycle unless out_stall holds it. Config writes are taken every
// cycle and must only happen while no request is in flight.
module dual_incremental_pid_speed
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic signed [dips_pkg::DATA_W-1:0]      target_speed,
    input  logic signed [dips_pkg::DATA_W-1:0]      left_count,
    input  logic signed [dips_pkg::DATA_W-1:0]      right_count,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic [dips_pkg::LIMIT_W-1:0]            left_duty,
    output logic                                    left_reverse,
    output logic [dips_pkg::LIMIT_W-1:0]            right_duty,
    output logic                                    right_reverse,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [dips_pkg::IDX_W-1:0]              cfg_index,
    input  logic [dips_pkg::CFG_W-1:0]              cfg_data
);

    dips_pkg::gain_set_t                    left_gains;
    dips_pkg::gain_set_t                    right_gains;
    logic [dips_pkg::LIMIT_W-1:0]           limit;
    dips_pkg::stage_en_t                    en;
    logic                                   v1_reg;
    logic                                   v2_reg;
    logic                                   v3_reg;
    logic                                   v4_reg;
    logic signed [dips_pkg::DATA_W-1:0]     left_drive;
    logic signed [dips_pkg::DATA_W-1:0]     right_drive;
    logic [dips_pkg::DATA_W-1:0]            left_mag;
    logic [dips_pkg::DATA_W-1:0]            right_mag;

    assign cfg_ready = 1'b1;

    dips_cfg u_cfg
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .left_gains  (left_gains),
        .right_gains (right_gains),
        .limit       (limit)
    );

    always_comb
    begin
        en.s4    = v3_reg && (!v4_reg || !out_stall);
        en.s3    = v2_reg && (!v3_reg || en.s4);
        en.s2    = v1_reg && (!v2_reg || en.s3);
        in_stall = v1_reg && !en.s2;
        en.s1    = in_valid && !in_stall;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en.s1)
                v1_reg <= 1'b1;
            else if (en.s2)
                v1_reg <= 1'b0;
            if (en.s2)
                v2_reg <= 1'b1;
            else if (en.s3)
                v2_reg <= 1'b0;
            if (en.s3)
                v3_reg <= 1'b1;
            else if (en.s4)
                v3_reg <= 1'b0;
            if (en.s4)
                v4_reg <= 1'b1;
            else if (!out_stall)
                v4_reg <= 1'b0;
        end
    end

    dips_lane u_left
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .target (target_speed),
        .count  (left_count),
        .gains  (left_gains),
        .limit  (limit),
        .drive  (left_drive)
    );

    dips_lane u_right
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .target (target_speed),
        .count  (right_count),
        .gains  (right_gains),
        .limit  (limit),
        .drive  (right_drive)
    );

    // sign/magnitude split of both drives
    always_comb
    begin
        left_mag      = left_drive[dips_pkg::DATA_W-1] ? -left_drive : left_drive;
        right_mag     = right_drive[dips_pkg::DATA_W-1] ? -right_drive : right_drive;
        left_duty     = left_mag[dips_pkg::LIMIT_W-1:0];
        right_duty    = right_mag[dips_pkg::LIMIT_W-1:0];
        left_reverse  = left_drive[dips_pkg::DATA_W-1];
        right_reverse = right_drive[dips_pkg::DATA_W-1];
    end

    assign out_valid = v4_reg;

endmodule
